// ===== sv/qds_pkg.sv =====
package qds_pkg;

	localparam int KEY_IN_W = 32;
	localparam int CNT_W = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int MAX_CAP = 16;

	localparam logic [1:0] KIND_POST = 2'd0;
	localparam logic [1:0] KIND_INCOMING = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_SUPPRESSED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_SENT = 1'b1;

	localparam logic [1:0] REG_DEFER = 2'd0;
	localparam logic [1:0] REG_HISTORY = 2'd1;
	localparam logic [1:0] REG_MAXQ = 2'd2;

	localparam logic [15:0] DEFER_RESET = 16'd100;
	localparam logic [15:0] HISTORY_RESET = 16'd100;
	localparam logic [4:0] MAXQ_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_POST,
		CMD_INCOMING,
		CMD_TICK
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t cmd;
		logic [KEY_IN_W-1:0] key;
		logic send_now;
	} cmd_t;

	typedef struct packed {
		logic result_kind;
		logic [1:0] status;
		logic [KEY_IN_W-1:0] sent_key;
		logic [3:0] packet_number;
		logic end_of_packet;
		logic last;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0] defer_ticks;
		logic [CNT_W-1:0] history_ticks;
		logic [4:0] max_q;
	} cfg_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SCAN,
		E_ACT,
		E_TICK_DEC,
		E_OUTER,
		E_INNER,
		E_FLUSH
	} eng_state_t;

endpackage

// ===== sv/qds_front.sv =====
module qds_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] kind,
	input  logic [qds_pkg::KEY_IN_W-1:0] query_key,
	input  logic send_now,
	output logic cmd_valid,
	output qds_pkg::cmd_t cmd_data,
	input  logic cmd_pop
);

	// Two-entry command queue; unknown kinds are accepted and discarded.
	qds_pkg::cmd_t slot_q [2];
	logic rd_q;
	logic wr_q;
	logic [1:0] cnt_q;
	logic known;
	logic enq;
	logic deq;
	qds_pkg::cmd_t cls;

	always_comb begin
		cls.key = query_key;
		cls.send_now = send_now;
		known = 1'b1;
		case (kind)
			qds_pkg::KIND_POST: cls.cmd = qds_pkg::CMD_POST;
			qds_pkg::KIND_INCOMING: cls.cmd = qds_pkg::CMD_INCOMING;
			qds_pkg::KIND_TICK: cls.cmd = qds_pkg::CMD_TICK;
			default: begin
				cls.cmd = qds_pkg::CMD_TICK;
				known = 1'b0;
			end
		endcase
	end

	assign full = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_data = slot_q[rd_q];
	assign enq = push && !full && known;
	assign deq = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_q <= !wr_q;
			if (deq) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) slot_q[wr_q] <= cls;
	end

endmodule

// ===== sv/qds_res_fifo.sv =====
module qds_res_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  qds_pkg::res_t din,
	output logic full,
	input  logic pop,
	output qds_pkg::res_t dout,
	output logic empty
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	qds_pkg::res_t mem_q [DEPTH];
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wr_q;
	logic [AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule

// ===== sv/qds_engine.sv =====
module qds_engine #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  qds_pkg::cfg_t cfg,
	input  logic cmd_valid,
	input  qds_pkg::cmd_t cmd_data,
	output logic cmd_pop,
	output logic res_push,
	output qds_pkg::res_t res_data,
	input  logic res_full
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = qds_pkg::CNT_W;

	qds_pkg::eng_state_t state_q, state_d;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] hist_q;
	logic [KEY_WIDTH-1:0] key_q [TABLE_DEPTH];
	logic [CW-1:0] cnt_q [TABLE_DEPTH];

	qds_pkg::cmd_t cur_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] i_q;
	logic [4:0] n_q;
	logic [4:0] count_q;
	logic [3:0] pkt_q;
	qds_pkg::res_t held_q;
	logic hv_q;
	logic fh_q, fp_q, ff_q;
	logic [AW-1:0] pend_idx_q;
	logic [AW-1:0] free_idx_q;
	logic [CW-1:0] pend_cnt_q;

	logic [AW-1:0] rd_idx;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [CW-1:0] rd_cnt;
	logic rd_valid, rd_hist;
	logic [KEY_WIDTH-1:0] cur_key;
	logic key_eq;
	logic [4:0] cap;
	logic [CW-1:0] when;
	logic stall_out;
	logic outer_done, head_due, outer_send, outer_skip;
	logic inner_done, inner_send, inner_skip;
	logic act_go;
	logic [1:0] post_status;
	qds_pkg::res_t new_sent;

	// One read port into the table: the outer pointer while looking for due
	// heads, the shared scan pointer otherwise.
	assign rd_idx = (state_q == qds_pkg::E_OUTER) ? i_q[AW-1:0] : ptr_q[AW-1:0];
	assign rd_key = key_q[rd_idx];
	assign rd_cnt = cnt_q[rd_idx];
	assign rd_valid = valid_q[rd_idx];
	assign rd_hist = hist_q[rd_idx];
	assign cur_key = KEY_WIDTH'(cur_q.key);
	assign key_eq = (rd_key == cur_key);
	assign when = cur_q.send_now ? '0 : cfg.defer_ticks;

	always_comb begin
		if (cfg.max_q == 5'd0) cap = 5'd1;
		else if (cfg.max_q > 5'(qds_pkg::MAX_CAP)) cap = 5'(qds_pkg::MAX_CAP);
		else cap = cfg.max_q;
	end

	assign stall_out = hv_q && res_full;
	assign outer_done = (i_q == PW'(TABLE_DEPTH)) || (n_q == 5'(qds_pkg::RESULT_LIMIT));
	assign head_due = rd_valid && !rd_hist && (rd_cnt == '0);
	assign outer_send = (state_q == qds_pkg::E_OUTER) && !outer_done && head_due && !stall_out;
	assign outer_skip = (state_q == qds_pkg::E_OUTER) && !outer_done && !head_due;
	assign inner_done = (ptr_q == PW'(TABLE_DEPTH)) || (count_q >= cap) ||
		(n_q == 5'(qds_pkg::RESULT_LIMIT));
	assign inner_send = (state_q == qds_pkg::E_INNER) && !inner_done && rd_valid && !rd_hist &&
		!stall_out;
	assign inner_skip = (state_q == qds_pkg::E_INNER) && !inner_done && !(rd_valid && !rd_hist);
	assign act_go = (state_q == qds_pkg::E_ACT) &&
		((cur_q.cmd != qds_pkg::CMD_POST) || !res_full);

	always_comb begin
		if (fh_q) post_status = qds_pkg::ST_SUPPRESSED;
		else if (fp_q || ff_q) post_status = qds_pkg::ST_ACCEPTED;
		else post_status = qds_pkg::ST_DROPPED;
	end

	always_comb begin
		new_sent.result_kind = qds_pkg::RES_SENT;
		new_sent.status = qds_pkg::ST_ACCEPTED;
		new_sent.sent_key = qds_pkg::KEY_IN_W'(rd_key);
		new_sent.packet_number = pkt_q;
		new_sent.end_of_packet = 1'b0;
		new_sent.last = 1'b0;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		res_data = held_q;
		case (state_q)
			qds_pkg::E_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd_data.cmd == qds_pkg::CMD_TICK) ?
						qds_pkg::E_TICK_DEC : qds_pkg::E_SCAN;
				end
			end
			qds_pkg::E_SCAN: begin
				if (ptr_q == PW'(TABLE_DEPTH - 1)) state_d = qds_pkg::E_ACT;
			end
			qds_pkg::E_ACT: begin
				if (cur_q.cmd == qds_pkg::CMD_POST) begin
					res_data.result_kind = qds_pkg::RES_STATUS;
					res_data.status = post_status;
					res_data.sent_key = '0;
					res_data.packet_number = '0;
					res_data.end_of_packet = 1'b0;
					res_data.last = 1'b1;
					res_push = !res_full;
				end
				if (act_go) state_d = qds_pkg::E_IDLE;
			end
			qds_pkg::E_TICK_DEC: begin
				state_d = qds_pkg::E_OUTER;
			end
			qds_pkg::E_OUTER: begin
				if (outer_done) state_d = qds_pkg::E_FLUSH;
				else if (outer_send) begin
					res_push = hv_q;
					state_d = qds_pkg::E_INNER;
				end
			end
			qds_pkg::E_INNER: begin
				if (inner_done) state_d = qds_pkg::E_OUTER;
				else if (inner_send) res_push = hv_q;
			end
			qds_pkg::E_FLUSH: begin
				res_data.last = 1'b1;
				if (!hv_q) state_d = qds_pkg::E_IDLE;
				else if (!res_full) begin
					res_push = 1'b1;
					state_d = qds_pkg::E_IDLE;
				end
			end
			default: state_d = qds_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= qds_pkg::E_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hist_q <= '0;
			ptr_q <= '0;
			i_q <= '0;
			n_q <= '0;
			count_q <= '0;
			pkt_q <= '0;
			hv_q <= 1'b0;
			fh_q <= 1'b0;
			fp_q <= 1'b0;
			ff_q <= 1'b0;
		end else begin
			case (state_q)
				qds_pkg::E_IDLE: begin
					ptr_q <= '0;
					fh_q <= 1'b0;
					fp_q <= 1'b0;
					ff_q <= 1'b0;
				end
				qds_pkg::E_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (rd_valid && rd_hist && key_eq) fh_q <= 1'b1;
					if (rd_valid && !rd_hist && key_eq) fp_q <= 1'b1;
					if (!rd_valid) ff_q <= 1'b1;
				end
				qds_pkg::E_ACT: begin
					if (act_go) begin
						if (cur_q.cmd == qds_pkg::CMD_POST) begin
							if (!fh_q && !fp_q && ff_q) begin
								valid_q[free_idx_q] <= 1'b1;
								hist_q[free_idx_q] <= 1'b0;
							end
						end else if (fp_q) begin
							hist_q[pend_idx_q] <= 1'b1;
						end else if (ff_q) begin
							valid_q[free_idx_q] <= 1'b1;
							hist_q[free_idx_q] <= 1'b1;
						end
					end
				end
				qds_pkg::E_TICK_DEC: begin
					for (int k = 0; k < TABLE_DEPTH; k++) begin
						if (valid_q[k] && hist_q[k] && (cnt_q[k] <= CW'(1)))
							valid_q[k] <= 1'b0;
					end
					i_q <= '0;
					n_q <= '0;
					pkt_q <= '0;
					hv_q <= 1'b0;
				end
				qds_pkg::E_OUTER: begin
					if (outer_send) begin
						hist_q[rd_idx] <= 1'b1;
						hv_q <= 1'b1;
						n_q <= n_q + 1'b1;
						count_q <= 5'd1;
						ptr_q <= '0;
						i_q <= i_q + 1'b1;
					end else if (outer_skip) begin
						i_q <= i_q + 1'b1;
					end
				end
				qds_pkg::E_INNER: begin
					if (inner_done) pkt_q <= pkt_q + 1'b1;
					else if (inner_send) begin
						hist_q[rd_idx] <= 1'b1;
						n_q <= n_q + 1'b1;
						count_q <= count_q + 1'b1;
						ptr_q <= ptr_q + 1'b1;
					end else if (inner_skip) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				qds_pkg::E_FLUSH: begin
					if (!res_full) hv_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			qds_pkg::E_IDLE: begin
				if (cmd_pop) cur_q <= cmd_data;
			end
			qds_pkg::E_SCAN: begin
				if (rd_valid && !rd_hist && key_eq && !fp_q) begin
					pend_idx_q <= rd_idx;
					pend_cnt_q <= rd_cnt;
				end
				if (!rd_valid && !ff_q) free_idx_q <= rd_idx;
			end
			qds_pkg::E_ACT: begin
				if (act_go) begin
					if (cur_q.cmd == qds_pkg::CMD_POST) begin
						if (!fh_q && fp_q) begin
							if (when < pend_cnt_q) cnt_q[pend_idx_q] <= when;
						end else if (!fh_q && ff_q) begin
							key_q[free_idx_q] <= cur_key;
							cnt_q[free_idx_q] <= when;
						end
					end else if (fp_q) begin
						cnt_q[pend_idx_q] <= cfg.history_ticks;
					end else if (ff_q) begin
						key_q[free_idx_q] <= cur_key;
						cnt_q[free_idx_q] <= cfg.history_ticks;
					end
				end
			end
			qds_pkg::E_TICK_DEC: begin
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					if (valid_q[k] && (cnt_q[k] != '0)) cnt_q[k] <= cnt_q[k] - 1'b1;
				end
			end
			qds_pkg::E_OUTER: begin
				if (outer_send) begin
					cnt_q[rd_idx] <= cfg.history_ticks;
					held_q <= new_sent;
				end
			end
			qds_pkg::E_INNER: begin
				if (inner_done) held_q.end_of_packet <= 1'b1;
				else if (inner_send) begin
					cnt_q[rd_idx] <= cfg.history_ticks;
					held_q <= new_sent;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/query_duplicate_suppression_scheduler_top.sv =====
// A post or incoming query is taken from the command queue in the idle
// state, one table slot is compared per scan step, and the result is then
// applied in one update state, which a post holds while the result queue is
// full; a post's status beat is written to the result queue as it leaves it.
// The engine takes no new command until it is back in the idle state; a tick
// walks the table for due heads and then, per packet, for further keys, all
// through the single table read port.
// Reset: arst_n clears the table's valid bits and the queues at once and
// loads the default registers; no clearing pass is needed.
module query_duplicate_suppression_scheduler_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] kind,
	input  logic [31:0] query_key,
	input  logic send_now,
	output logic empty,
	input  logic pop,
	output logic result_kind,
	output logic [1:0] status,
	output logic [31:0] sent_key,
	output logic [3:0] packet_number,
	output logic end_of_packet,
	output logic last,
	input  logic wr_en,
	input  logic [1:0] wr_index,
	input  logic [15:0] wr_data
);

	// Configuration registers. The user must make writes only while the block
	// is idle; the block does not enforce this. The engine reads them directly.
	qds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.defer_ticks <= qds_pkg::DEFER_RESET;
			cfg_q.history_ticks <= qds_pkg::HISTORY_RESET;
			cfg_q.max_q <= qds_pkg::MAXQ_RESET;
		end else if (wr_en) begin
			case (wr_index)
				qds_pkg::REG_DEFER: cfg_q.defer_ticks <= wr_data;
				qds_pkg::REG_HISTORY: cfg_q.history_ticks <= wr_data;
				qds_pkg::REG_MAXQ: cfg_q.max_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// The front classifies each accepted beat and queues known kinds as commands;
	// the engine walks the table for each command; results drain through a
	// small queue so the engine keeps working while the consumer stalls, until the queue is full.
	logic cmd_valid;
	logic cmd_pop;
	qds_pkg::cmd_t cmd_data;
	logic res_push;
	logic res_full;
	qds_pkg::res_t res_in;
	qds_pkg::res_t res_out;

	qds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.query_key(query_key),
		.send_now(send_now),
		.cmd_valid(cmd_valid),
		.cmd_data(cmd_data),
		.cmd_pop(cmd_pop)
	);

	qds_engine #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH(KEY_WIDTH)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_data(cmd_data),
		.cmd_pop(cmd_pop),
		.res_push(res_push),
		.res_data(res_in),
		.res_full(res_full)
	);

	qds_res_fifo u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din(res_in),
		.full(res_full),
		.pop(pop),
		.dout(res_out),
		.empty(empty)
	);

	assign result_kind = res_out.result_kind;
	assign status = res_out.status;
	assign sent_key = res_out.sent_key;
	assign packet_number = res_out.packet_number;
	assign end_of_packet = res_out.end_of_packet;
	assign last = res_out.last;

	// The engine never offers a beat that the result queue cannot take.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result beat pushed into a full queue");

	// A post status beat is always the only, and so the last, beat of its item.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result_kind == qds_pkg::RES_STATUS)) |-> last)
		else $error("post status beat without last");

	// The last sent key of a tick also closes its packet.
	a_last_closes_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result_kind == qds_pkg::RES_SENT) && last) |-> end_of_packet)
		else $error("tick ended inside an open packet");

endmodule
